// ===== rtl/scb_pkg.sv =====
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants for the sprite column blit block: action codes,
// sprite limits and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scb_pkg;

	// action codes carried on the item channel
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_BLIT  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// tallest sprite column in pages, and sprite word width
	localparam int unsigned SPRITE_MAX_PAGES = 4;
	localparam int unsigned SPRITE_BITS      = 32;

	// controller -> datapath
	typedef struct packed {
		logic load;   // item transfer: latch item, start column read
		logic sweep;  // zero one frame column, advance sweep counter
		logic emit;   // write back blit, load result register
	} scb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_last;  // sweep counter sits on the last column
	} scb_status_t;

endpackage

`default_nettype wire

// ===== rtl/scb_item_if.sv =====
// ----------------------------------------------------------------------------
// scb_item_if
// Input item channel: valid/ready handshake with the action payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface scb_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [8:0]  column_x;
	logic [4:0]         bottom_y;
	logic [2:0]         height_pages;
	logic [31:0]        sprite_bits;
	logic               sprite_start;

	modport source (
		output valid, action, column_x, bottom_y, height_pages, sprite_bits,
		       sprite_start,
		input  ready
	);
	modport sink (
		input  valid, action, column_x, bottom_y, height_pages, sprite_bits,
		       sprite_start,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/scb_result_if.sv =====
// ----------------------------------------------------------------------------
// scb_result_if
// Result channel: valid/ready handshake with hit flags and read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface scb_result_if;
	logic        valid;
	logic        ready;
	logic        column_hit;
	logic        sprite_hit;
	logic [31:0] read_bits;

	modport source (
		output valid, column_hit, sprite_hit, read_bits,
		input  ready
	);
	modport sink (
		input  valid, column_hit, sprite_hit, read_bits,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/scb_ram.sv =====
// ----------------------------------------------------------------------------
// scb_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scb_ctrl.sv =====
// ----------------------------------------------------------------------------
// scb_ctrl
// Controller: sequences the reset sweep, clear sweeps, the column
// read-modify-write of blits and reads, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire logic [1:0]          item_action,
	output logic                     item_ready,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output scb_pkg::scb_cmd_t        cmd,
	input  wire scb_pkg::scb_status_t status
);
	import scb_pkg::*;

	typedef enum logic [3:0] {
		S_INIT  = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CLEAR = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   slot_free;
	logic   xfer;

	// result slot frees when empty or taken this cycle
	assign slot_free = !result_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE);
	assign xfer       = item_valid && item_ready;
	assign result_valid = result_valid_q;

	// commands and next state
	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.sweep = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (xfer) begin
					cmd.load = 1'b1;
					state_d  = (item_action == ACT_CLEAR) ? S_CLEAR : S_EMIT;
				end
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scb_datapath.sv =====
// ----------------------------------------------------------------------------
// scb_datapath
// Datapath: frame column store, sweep counter, sprite placement shifter,
// collision test, sticky hit flag and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_datapath #(
	parameter int unsigned FRAME_WIDTH = 128,
	parameter int unsigned FRAME_PAGES = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scb_pkg::scb_cmd_t   cmd,
	output scb_pkg::scb_status_t     status,
	input  wire logic [1:0]          action,
	input  wire logic signed [8:0]   column_x,
	input  wire logic [4:0]          bottom_y,
	input  wire logic [2:0]          height_pages,
	input  wire logic [31:0]         sprite_bits,
	input  wire logic                sprite_start,
	output logic                     column_hit,
	output logic                     sprite_hit,
	output logic [31:0]              read_bits
);
	import scb_pkg::*;

	localparam int unsigned COL_BITS = FRAME_PAGES * 8;
	localparam int unsigned AW       = $clog2(FRAME_WIDTH);

	// latched item
	logic [1:0]          act_q;
	logic                in_frame_q;
	logic                start_q;
	logic [AW-1:0]       addr_q;
	logic [COL_BITS-1:0] placed_q;

	// sticky hit and sweep counter
	logic                acc_q;
	logic [AW-1:0]       sweep_q;

	// placement
	logic                in_frame;
	logic [2:0]          pages;
	logic [5:0]          nbits;
	logic [31:0]         keep_mask;
	logic [63:0]         ext;
	logic [7:0]          offset;
	logic [7:0]          neg_offset;
	logic [63:0]         shifted;

	// store access
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COL_BITS-1:0] ram_wdata;
	logic [COL_BITS-1:0] old_col;
	logic                hit;
	logic                wr_back;

	// column range check on the signed x
	assign in_frame = !column_x[8] && ({24'd0, column_x[7:0]} < 32'(FRAME_WIDTH));

	// clamp height, mask sprite, shift to its frame rows
	always_comb begin
		if (height_pages == 3'd0) begin
			pages = 3'd0;
		end else if (height_pages > 3'(SPRITE_MAX_PAGES)) begin
			pages = 3'(SPRITE_MAX_PAGES);
		end else begin
			pages = height_pages;
		end
		nbits      = {pages, 3'b000};
		keep_mask  = 32'((33'd1 << nbits) - 33'd1);
		ext        = {32'd0, sprite_bits & keep_mask};
		offset     = 8'(COL_BITS) - {2'b00, nbits} - {3'b000, bottom_y};
		neg_offset = 8'd0 - offset;
		// negative offset pushes rows above the top and drops them
		shifted    = offset[7] ? (ext >> neg_offset[5:0]) : (ext << offset[5:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q      <= action;
			in_frame_q <= in_frame;
			start_q    <= sprite_start;
			addr_q     <= AW'(column_x[7:0]);
			placed_q   <= shifted[COL_BITS-1:0];
		end
	end

	// collision and write-back
	assign hit     = (act_q == ACT_BLIT) && in_frame_q && ((old_col & placed_q) != '0);
	assign wr_back = cmd.emit && (act_q == ACT_BLIT) && in_frame_q;

	assign ram_we    = cmd.sweep || wr_back;
	assign ram_waddr = cmd.sweep ? sweep_q : addr_q;
	assign ram_wdata = cmd.sweep ? '0 : (old_col | placed_q);

	scb_ram #(
		.WIDTH (COL_BITS),
		.DEPTH (FRAME_WIDTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.load),
		.raddr (AW'(column_x[7:0])),
		.rdata (old_col)
	);

	// sweep counter wraps to zero after the last column
	assign status.sweep_last = (sweep_q == AW'(FRAME_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			acc_q   <= 1'b0;
		end else begin
			if (cmd.sweep) begin
				sweep_q <= status.sweep_last ? '0 : sweep_q + AW'(1);
			end
			if (cmd.emit && (act_q == ACT_BLIT)) begin
				acc_q <= (acc_q && !start_q) || hit;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			column_hit <= hit;
			sprite_hit <= (act_q == ACT_BLIT) ? ((acc_q && !start_q) || hit) : acc_q;
			read_bits  <= ((act_q == ACT_READ) && in_frame_q) ? 32'(old_col) : 32'd0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sprite_column_blit_collide.sv =====
// ----------------------------------------------------------------------------
// sprite_column_blit_collide
// Page-organized monochrome frame store with OR-blit of sprite columns,
// collision reporting, column readback and whole-frame clear.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of actions (clear, blit, read) and their
//            operands. One item is taken at a time.
//   result : valid/ready channel, one result per item: column_hit,
//            sprite_hit and read_bits.
// Timing:
//   Blit and read: the column is read from the frame RAM on the transfer
//   edge. Once the result slot is free, a blit writes the modified column
//   back on the edge where the result register loads. The next item is not
//   taken until the result register has loaded.
//   Clear: one column zeroed per cycle over the whole frame, then the result
//   register loads once the result slot is free.
// Reset:
//   Reset clears the hit flag and starts a clearing pass over the frame RAM;
//   item.ready stays low until it finishes.
// Stall:
//   A result waits in its register while result.ready is low; one more item
//   is taken meanwhile and waits in the item latch until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_column_blit_collide #(
	parameter int unsigned FRAME_WIDTH = 128,
	parameter int unsigned FRAME_PAGES = 4
) (
	input wire logic  clk,
	input wire logic  arst_n,
	scb_item_if.sink  item,
	scb_result_if.source result
);
	import scb_pkg::*;

	scb_cmd_t    cmd;
	scb_status_t status;

	scb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_action  (item.action),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.status       (status)
	);

	scb_datapath #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_PAGES (FRAME_PAGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.action       (item.action),
		.column_x     (item.column_x),
		.bottom_y     (item.bottom_y),
		.height_pages (item.height_pages),
		.sprite_bits  (item.sprite_bits),
		.sprite_start (item.sprite_start),
		.column_hit   (result.column_hit),
		.sprite_hit   (result.sprite_hit),
		.read_bits    (result.read_bits)
	);

endmodule

`default_nettype wire

// ===== rtl/scb_checker.sv =====
// ----------------------------------------------------------------------------
// scb_checker
// Port-level checks for the sprite column blit block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        column_hit,
	input wire logic        sprite_hit,
	input wire logic [31:0] read_bits
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(column_hit) && $stable(sprite_hit) &&
			$stable(read_bits))
		else $error("result changed while stalled");

	// one item in flight: ready drops after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in work");

	// a column hit always sets the sticky flag
	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && column_hit |-> sprite_hit)
		else $error("column hit without sprite hit");

	// blits that hit never return read data
	a_hit_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && column_hit |-> read_bits == 32'd0)
		else $error("read data on a blit result");

endmodule

bind sprite_column_blit_collide scb_checker u_scb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.column_hit   (result.column_hit),
	.sprite_hit   (result.sprite_hit),
	.read_bits    (result.read_bits)
);

`default_nettype wire

// ===== tb/tb_sprite_column_blit_collide.sv =====
// ----------------------------------------------------------------------------
// tb_sprite_column_blit_collide
// Self-checking bench for the sprite column blit block. A shadow copy of the
// frame and the sticky hit flag predicts every result. Directed items cover
// the corners, then sprite runs, readbacks, clears and random noise run under
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_sprite_column_blit_collide;
	import scb_pkg::*;

	localparam int unsigned FRAME_WIDTH = 128;
	localparam int unsigned FRAME_PAGES = 4;
	localparam int          COL_BITS    = FRAME_PAGES * 8;
	localparam logic [1:0]  ACT_UNUSED  = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1600;
	localparam int unsigned IDLE_PCT     = 16;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	typedef struct packed {
		logic [1:0]  action;
		logic [8:0]  column_x;
		logic [4:0]  bottom_y;
		logic [2:0]  height_pages;
		logic [31:0] sprite_bits;
		logic        sprite_start;
	} blit_item_t;

	typedef struct packed {
		logic        column_hit;
		logic        sprite_hit;
		logic [31:0] read_bits;
	} blit_result_t;

	// Shadow frame plus queue of predicted results
	class blit_scoreboard;
		logic [COL_BITS-1:0] frame [FRAME_WIDTH];
		logic                hit_flag;
		blit_result_t        pending_results [$];
		int unsigned         errors;

		function new();
			foreach (frame[i])
				frame[i] = '0;
			hit_flag = 1'b0;
			errors   = 0;
		endfunction

		// sprite column shifted into frame rows, rows off the frame dropped
		function logic [COL_BITS-1:0] place_column(logic [31:0] bits, logic [2:0] pages,
				logic [4:0] bottom);
			int          h;
			int          offset;
			logic [63:0] wide;
			h = (pages > SPRITE_MAX_PAGES) ? int'(SPRITE_MAX_PAGES) : int'(pages);
			if (h == 0)
				return '0;
			wide = {32'd0, bits} & ((64'd1 << (8 * h)) - 64'd1);
			offset = COL_BITS - 8 * h - int'(bottom);
			if (offset >= 0)
				wide = wide << offset;
			else
				wide = wide >> (-offset);
			return wide[COL_BITS-1:0];
		endfunction

		function void accept_item(blit_item_t it);
			blit_result_t        r;
			logic [COL_BITS-1:0] placed;
			int                  x;
			bit                  in_frame;
			r = '0;
			x = int'($signed(it.column_x));
			in_frame = (x >= 0) && (x < int'(FRAME_WIDTH));
			case (it.action)
				ACT_CLEAR: begin
					foreach (frame[i])
						frame[i] = '0;
				end
				ACT_BLIT: begin
					if (it.sprite_start)
						hit_flag = 1'b0;
					if (in_frame) begin
						placed = place_column(it.sprite_bits, it.height_pages, it.bottom_y);
						r.column_hit = |(frame[x] & placed);
						frame[x] = frame[x] | placed;
						hit_flag = hit_flag | r.column_hit;
					end
				end
				ACT_READ: begin
					if (in_frame)
						r.read_bits = frame[x][31:0];
				end
				default: ;
			endcase
			r.sprite_hit = hit_flag;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic column_hit, logic sprite_hit, logic [31:0] read_bits);
			blit_result_t want;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (column_hit !== want.column_hit) begin
				$error("column_hit: expected %0b, got %0b", want.column_hit, column_hit);
				errors++;
			end
			if (sprite_hit !== want.sprite_hit) begin
				$error("sprite_hit: expected %0b, got %0b", want.sprite_hit, sprite_hit);
				errors++;
			end
			if (read_bits !== want.read_bits) begin
				$error("read_bits: expected %08h, got %08h", want.read_bits, read_bits);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	scb_item_if   item ();
	scb_result_if result ();

	sprite_column_blit_collide #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_PAGES (FRAME_PAGES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	blit_scoreboard sb = new();

	int unsigned items_sent  = 0;
	int unsigned cycle_count = 0;
	bit          no_idle     = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stalls, checked at the transfer edge
	always @(negedge clk) begin
		result.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.column_hit, result.sprite_hit, result.read_bits);
	end

	function automatic blit_item_t mk_item(logic [1:0] action, int x, int bottom, int pages,
			logic [31:0] bits, bit start);
		blit_item_t it;
		it.action       = action;
		it.column_x     = 9'(x);
		it.bottom_y     = 5'(bottom);
		it.height_pages = 3'(pages);
		it.sprite_bits  = bits;
		it.sprite_start = start;
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(blit_item_t it);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid        <= 1'b1;
		item.action       <= it.action;
		item.column_x     <= it.column_x;
		item.bottom_y     <= it.bottom_y;
		item.height_pages <= it.height_pages;
		item.sprite_bits  <= it.sprite_bits;
		item.sprite_start <= it.sprite_start;
		do
			@(posedge clk);
		while (!item.ready);
		sb.accept_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	// sender holds off until every predicted result has come back
	task automatic wait_results_drained();
		item.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] sprite_pattern();
		case ($urandom_range(3))
			0:       return $urandom();
			1, 2:    return $urandom() & $urandom() & $urandom();
			default: return 32'd1 << $urandom_range(31);
		endcase
	endfunction

	task automatic send_noise();
		send_item(mk_item(2'($urandom_range(3)), int'($urandom_range(511)),
			int'($urandom_range(31)), int'($urandom_range(7)), $urandom(), 1'($urandom())));
	endtask

	// consecutive columns of one sprite, sometimes broken, then some readback
	task automatic blit_sprite_run();
		int n;
		int x0;
		int bottom;
		int pages;
		int reads;
		bit first_start;
		n      = $urandom_range(1, 12);
		x0     = int'($urandom_range(143)) - 8;
		bottom = $urandom_range(31);
		pages  = $urandom_range(1, 4);
		first_start = ($urandom_range(9) != 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				send_noise();
			send_item(mk_item(ACT_BLIT, x0 + i, bottom, pages, sprite_pattern(),
				(i == 0) ? first_start : 1'b0));
		end
		reads = $urandom_range(0, 3);
		for (int k = 0; k < reads; k++)
			send_item(mk_item(ACT_READ, x0 + int'($urandom_range(n - 1)), 0, 0, 32'd0, 1'b0));
	endtask

	task automatic run_directed();
		// read of a never written column after reset
		send_item(mk_item(ACT_READ, 0, 0, 0, 32'd0, 1'b0));
		// full column, then the same again to hit
		send_item(mk_item(ACT_BLIT, 0, 0, 4, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_item(ACT_BLIT, 0, 0, 4, 32'hFFFF_FFFF, 1'b0));
		send_item(mk_item(ACT_READ, 0, 0, 0, 32'd0, 1'b1));
		// bottom edge high: rows pushed above the top are dropped
		send_item(mk_item(ACT_BLIT, 127, 31, 1, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_item(ACT_BLIT, 126, 31, 4, 32'hFFFF_FFFF, 1'b0));
		send_item(mk_item(ACT_READ, 127, 0, 0, 32'd0, 1'b0));
		send_item(mk_item(ACT_READ, 126, 0, 0, 32'd0, 1'b0));
		// columns outside the frame, start still clears the flag
		send_item(mk_item(ACT_BLIT, -1, 0, 4, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_item(ACT_BLIT, 128, 0, 4, 32'hFFFF_FFFF, 1'b0));
		send_item(mk_item(ACT_BLIT, 255, 5, 2, 32'hA5A5_A5A5, 1'b0));
		send_item(mk_item(ACT_BLIT, -256, 9, 3, 32'h5A5A_5A5A, 1'b0));
		send_item(mk_item(ACT_READ, -256, 0, 0, 32'd0, 1'b0));
		send_item(mk_item(ACT_READ, 255, 0, 0, 32'd0, 1'b0));
		// zero height and oversized heights
		send_item(mk_item(ACT_BLIT, 5, 0, 0, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_item(ACT_BLIT, 6, 3, 7, 32'h8001_8001, 1'b0));
		send_item(mk_item(ACT_BLIT, 6, 3, 5, 32'h0001_0000, 1'b0));
		send_item(mk_item(ACT_READ, 6, 0, 0, 32'd0, 1'b0));
		// unused action shows the flag, clear keeps it
		send_item(mk_item(ACT_UNUSED, 6, 31, 7, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_item(ACT_CLEAR, 0, 31, 7, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_item(ACT_READ, 0, 0, 0, 32'd0, 1'b0));
		// empty sprite word on a clear frame, then a single pixel
		send_item(mk_item(ACT_BLIT, 64, 17, 2, 32'd0, 1'b0));
		send_item(mk_item(ACT_BLIT, 64, 0, 1, 32'h0000_0080, 1'b1));
		send_item(mk_item(ACT_READ, 64, 0, 0, 32'd0, 1'b0));
	endtask

	initial begin
		int unsigned target;
		int unsigned pick;
		arst_n            = 1'b0;
		item.valid        = 1'b0;
		item.action       = ACT_CLEAR;
		item.column_x     = '0;
		item.bottom_y     = '0;
		item.height_pages = '0;
		item.sprite_bits  = '0;
		item.sprite_start = 1'b0;
		result.ready      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		wait_results_drained();

		// random part, with one stretch where neither side idles
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			no_idle = (items_sent >= target - 900) && (items_sent < target - 600);
			pick = $urandom_range(99);
			if (pick < 68)
				blit_sprite_run();
			else if (pick < 78)
				send_item(mk_item(ACT_READ, int'($urandom_range(135)) - 4, 0, 0, 32'd0,
					1'($urandom())));
			else if (pick < 93)
				send_noise();
			else if (pick < 96)
				send_item(mk_item(ACT_CLEAR, int'($urandom_range(511)), 0, 0, $urandom(),
					1'($urandom())));
			else
				wait_results_drained();
		end
		no_idle = 1'b0;
		item.valid <= 1'b0;

		// drain, then let the block settle
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (FRAME_WIDTH + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
